@@ hw/rtl/hbu_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hbu_pkg - histogram binner shared definitions
// Item kinds, command control word, sequencer states and register indexes.
// ----------------------------------------------------------------------------
package hbu_pkg;

  localparam int HBU_MAX_BINS    = 256;
  localparam int HBU_COUNT_WIDTH = 32;
  localparam int CMD_Q_DEPTH     = 2;
  localparam int CFG_IDX_W       = 2;

  typedef enum logic [1:0] {
    KIND_BIN   = 2'd0,
    KIND_READ  = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_NOP   = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOWER = 2'd0,
    CFG_UPPER = 2'd1,
    CFG_BINS  = 2'd2,
    CFG_SCALE = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_SWEEP = 2'd0,
    ST_IDLE  = 2'd1,
    ST_EXEC  = 2'd2
  } back_state_t;

  // control part of a classified command word
  typedef struct packed {
    kind_t kind;
    logic  use_mem;
    logic  outlier;
  } cmd_ctrl_t;

endpackage
`default_nettype wire

@@ hw/rtl/hbu_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hbu_front - item intake and classification
// Range check and offset, Q16.16 scale multiply, round and saturate to a bin.
// ----------------------------------------------------------------------------
module hbu_front #(
  parameter int MAX_BINS = 256
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_push,
  output logic                               in_full,
  input  wire logic [1:0]                    in_kind,
  input  wire logic signed [31:0]            in_sample,
  input  wire logic [7:0]                    in_read_index,
  input  wire logic signed [31:0]            cfg_lower,
  input  wire logic signed [31:0]            cfg_upper,
  input  wire logic [8:0]                    cfg_bin_count,
  input  wire logic [31:0]                   cfg_bin_scale,
  output logic                               q_push,
  input  wire logic                          q_full,
  output hbu_pkg::cmd_ctrl_t                 q_ctrl,
  output logic [$clog2(MAX_BINS)-1:0]        q_addr
);
  import hbu_pkg::*;

  localparam int BIN_W = $clog2(MAX_BINS);
  localparam int NW    = $clog2(MAX_BINS + 1);

  logic [NW-1:0]    bins_used;
  logic [BIN_W-1:0] last_bin;
  logic             advance;
  logic             in_acc;

  logic             s1_v_r;
  kind_t            s1_kind_r;
  logic             s1_outlier_r;
  logic             s1_rd_ok_r;
  logic [31:0]      s1_offset_r;
  logic [7:0]       s1_ridx_r;

  logic             s2_v_r;
  kind_t            s2_kind_r;
  logic             s2_outlier_r;
  logic             s2_rd_ok_r;
  logic [63:0]      s2_prod_r;
  logic [7:0]       s2_ridx_r;

  logic [63:0]      rounded;
  logic [47:0]      idx_full;
  logic [BIN_W-1:0] idx;

  always_comb begin
    if (cfg_bin_count == 9'd0) begin
      bins_used = NW'(1);
    end else if (32'(cfg_bin_count) > 32'(MAX_BINS)) begin
      bins_used = NW'(MAX_BINS);
    end else begin
      bins_used = NW'(cfg_bin_count);
    end
  end

  assign last_bin = BIN_W'(bins_used - NW'(1));

  assign advance = !s2_v_r || !q_full;
  assign in_full = s1_v_r && !advance;
  assign in_acc  = in_push && !in_full;

  // stage 1: range check and offset from lower bound
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (!s1_v_r || advance) begin
      s1_v_r <= in_acc;
    end
    if (in_acc) begin
      s1_kind_r    <= kind_t'(in_kind);
      s1_outlier_r <= (in_sample > cfg_upper) || (in_sample < cfg_lower);
      s1_offset_r  <= in_sample - cfg_lower;
      s1_rd_ok_r   <= 32'(in_read_index) < 32'(bins_used);
      s1_ridx_r    <= in_read_index;
    end
  end

  // stage 2: scale multiply
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (advance) begin
      s2_v_r <= s1_v_r;
    end
    if (advance && s1_v_r) begin
      s2_kind_r    <= s1_kind_r;
      s2_outlier_r <= s1_outlier_r;
      s2_rd_ok_r   <= s1_rd_ok_r;
      s2_prod_r    <= 64'(s1_offset_r) * 64'(cfg_bin_scale);
      s2_ridx_r    <= s1_ridx_r;
    end
  end

  // round half up, saturate at the last bin in use
  assign rounded  = s2_prod_r + 64'h0000_0000_0000_8000;
  assign idx_full = rounded[63:16];
  assign idx      = (idx_full > 48'(last_bin)) ? last_bin : BIN_W'(idx_full);

  always_comb begin
    q_push       = s2_v_r;
    q_ctrl.kind  = s2_kind_r;
    q_ctrl.outlier = 1'b0;
    q_ctrl.use_mem = 1'b0;
    q_addr       = '0;
    case (s2_kind_r)
      KIND_BIN: begin
        q_ctrl.outlier = s2_outlier_r;
        q_ctrl.use_mem = !s2_outlier_r;
        q_addr         = idx;
      end
      KIND_READ: begin
        q_ctrl.use_mem = s2_rd_ok_r;
        q_addr         = BIN_W'(s2_ridx_r);
      end
      default: begin
        q_ctrl.use_mem = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ hw/rtl/hbu_cmd_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hbu_cmd_queue - command queue between intake and bin update
// Small register queue holding classified command words.
// ----------------------------------------------------------------------------
module hbu_cmd_queue #(
  parameter int ADDR_W = 8
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  output logic                     full,
  input  wire hbu_pkg::cmd_ctrl_t  push_ctrl,
  input  wire logic [ADDR_W-1:0]   push_addr,
  input  wire logic                pop,
  output logic                     empty,
  output hbu_pkg::cmd_ctrl_t       head_ctrl,
  output logic [ADDR_W-1:0]        head_addr
);
  import hbu_pkg::*;

  localparam int PTR_W = $clog2(CMD_Q_DEPTH);
  localparam int CNT_W = $clog2(CMD_Q_DEPTH + 1);

  cmd_ctrl_t         ctrl_q [CMD_Q_DEPTH];
  logic [ADDR_W-1:0] addr_q [CMD_Q_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [CNT_W-1:0]  count_r;
  logic              do_push;
  logic              do_pop;

  assign full      = count_r == CNT_W'(CMD_Q_DEPTH);
  assign empty     = count_r == '0;
  assign do_push   = push && !full;
  assign do_pop    = pop && !empty;
  assign head_ctrl = ctrl_q[rd_ptr_r];
  assign head_addr = addr_q[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(CMD_Q_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(CMD_Q_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
    if (do_push) begin
      ctrl_q[wr_ptr_r] <= push_ctrl;
      addr_q[wr_ptr_r] <= push_addr;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/hbu_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hbu_back - bin store update and result register
// Read-modify-write of the bin store, totals, clear sweep, one-word result.
// ----------------------------------------------------------------------------
module hbu_back #(
  parameter int MAX_BINS    = 256,
  parameter int COUNT_WIDTH = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         q_empty,
  output logic                              q_pop,
  input  wire hbu_pkg::cmd_ctrl_t           q_ctrl,
  input  wire logic [$clog2(MAX_BINS)-1:0]  q_addr,
  output logic                              out_empty,
  input  wire logic                         out_pop,
  output logic [31:0]                       out_bin_value,
  output logic [7:0]                        out_hit_index,
  output logic                              out_was_outlier,
  output logic [31:0]                       out_total_samples,
  output logic [31:0]                       out_outlier_total
);
  import hbu_pkg::*;

  localparam int BIN_W = $clog2(MAX_BINS);
  localparam int CW    = COUNT_WIDTH;

  function automatic logic [CW-1:0] bump(input logic [CW-1:0] c);
    return (&c) ? c : c + CW'(1);
  endfunction

  function automatic logic [31:0] rep32(input logic [CW-1:0] c);
    logic [63:0] w;
    w = 64'(c);
    return (w > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : w[31:0];
  endfunction

  logic [CW-1:0]    mem [MAX_BINS];
  back_state_t      state_r;
  back_state_t      state_nxt;
  logic [BIN_W-1:0] sweep_cnt_r;
  logic             sweep_last;
  cmd_ctrl_t        ctrl_r;
  logic [BIN_W-1:0] addr_r;
  logic [CW-1:0]    rd_data_r;
  logic [CW-1:0]    samples_r;
  logic [CW-1:0]    outliers_r;
  logic [CW-1:0]    samples_nxt;
  logic [CW-1:0]    outliers_nxt;
  logic [CW-1:0]    bumped;
  logic [31:0]      res_value;
  logic [7:0]       res_hit;
  logic             slot_free;
  logic             finish;
  logic             mem_we;
  logic [BIN_W-1:0] mem_waddr;
  logic [CW-1:0]    mem_wdata;
  logic             out_valid_r;
  logic [31:0]      out_bin_value_r;
  logic [7:0]       out_hit_index_r;
  logic             out_was_outlier_r;
  logic [31:0]      out_total_samples_r;
  logic [31:0]      out_outlier_total_r;

  assign slot_free  = !out_valid_r || out_pop;
  assign sweep_last = sweep_cnt_r == BIN_W'(MAX_BINS - 1);
  assign bumped     = bump(rd_data_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_SWEEP: begin
        if (sweep_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (!q_empty) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (slot_free) state_nxt = (ctrl_r.kind == KIND_CLEAR) ? ST_SWEEP : ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    q_pop     = 1'b0;
    finish    = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = addr_r;
    mem_wdata = bumped;
    case (state_r)
      ST_SWEEP: begin
        mem_we    = 1'b1;
        mem_waddr = sweep_cnt_r;
        mem_wdata = '0;
      end
      ST_IDLE: begin
        q_pop = !q_empty;
      end
      ST_EXEC: begin
        finish = slot_free;
        mem_we = slot_free && ctrl_r.kind == KIND_BIN && ctrl_r.use_mem;
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  always_comb begin
    samples_nxt  = samples_r;
    outliers_nxt = outliers_r;
    res_value    = 32'd0;
    res_hit      = 8'd0;
    case (ctrl_r.kind)
      KIND_BIN: begin
        samples_nxt = bump(samples_r);
        if (ctrl_r.outlier) outliers_nxt = bump(outliers_r);
        if (ctrl_r.use_mem) begin
          res_value = rep32(bumped);
          res_hit   = 8'(addr_r);
        end
      end
      KIND_READ: begin
        if (ctrl_r.use_mem) res_value = rep32(rd_data_r);
      end
      KIND_CLEAR: begin
        samples_nxt  = '0;
        outliers_nxt = '0;
      end
      default: begin
        res_value = 32'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (q_pop) rd_data_r <= mem[q_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_SWEEP;
      sweep_cnt_r <= '0;
      samples_r   <= '0;
      outliers_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_SWEEP) begin
        sweep_cnt_r <= sweep_last ? '0 : sweep_cnt_r + BIN_W'(1);
      end
      if (finish) begin
        samples_r   <= samples_nxt;
        outliers_r  <= outliers_nxt;
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
    if (q_pop) begin
      ctrl_r <= q_ctrl;
      addr_r <= q_addr;
    end
    if (finish) begin
      out_bin_value_r     <= res_value;
      out_hit_index_r     <= res_hit;
      out_was_outlier_r   <= ctrl_r.kind == KIND_BIN && ctrl_r.outlier;
      out_total_samples_r <= rep32(samples_nxt);
      out_outlier_total_r <= rep32(outliers_nxt);
    end
  end

  assign out_empty         = !out_valid_r;
  assign out_bin_value     = out_bin_value_r;
  assign out_hit_index     = out_hit_index_r;
  assign out_was_outlier   = out_was_outlier_r;
  assign out_total_samples = out_total_samples_r;
  assign out_outlier_total = out_outlier_total_r;

endmodule
`default_nettype wire

@@ hw/rtl/histogram_binner_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// histogram_binner_unit - fixed range histogram with outlier count
// Bins samples, reads single bins back and clears the store on request.
//
//   channel  handshake               payload
//   in       in_push / in_full       in_kind, in_sample, in_read_index
//   out      out_pop / out_empty     out_bin_value, out_hit_index,
//                                    out_was_outlier, out_total_samples,
//                                    out_outlier_total
//   cfg      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// Intake is a two-stage pipe (range check, multiply) that rounds into a
// two-word command queue. The bin store has one read and one write port;
// each word is read there, then updated, and the store side takes no new
// word before the update of the last one is done.
// A clear word adds a sweep that zeroes every bin; reset starts with the same sweep.
// A full result slot stalls the store side; intake runs on until the queue fills.
// ----------------------------------------------------------------------------
module histogram_binner_unit #(
  parameter int MAX_BINS    = hbu_pkg::HBU_MAX_BINS,
  parameter int COUNT_WIDTH = hbu_pkg::HBU_COUNT_WIDTH
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_push,
  output logic                                 in_full,
  input  wire logic [1:0]                      in_kind,
  input  wire logic signed [31:0]              in_sample,
  input  wire logic [7:0]                      in_read_index,
  output logic                                 out_empty,
  input  wire logic                            out_pop,
  output logic [31:0]                          out_bin_value,
  output logic [7:0]                           out_hit_index,
  output logic                                 out_was_outlier,
  output logic [31:0]                          out_total_samples,
  output logic [31:0]                          out_outlier_total,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [hbu_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [31:0]                     cfg_data
);
  import hbu_pkg::*;

  localparam int BIN_W = $clog2(MAX_BINS);

  logic signed [31:0] lower_r;
  logic signed [31:0] upper_r;
  logic [8:0]         bin_count_r;
  logic [31:0]        bin_scale_r;

  logic               q_push;
  logic               q_full;
  logic               q_pop;
  logic               q_empty;
  cmd_ctrl_t          q_in_ctrl;
  logic [BIN_W-1:0]   q_in_addr;
  cmd_ctrl_t          q_head_ctrl;
  logic [BIN_W-1:0]   q_head_addr;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lower_r     <= 32'sd0;
      upper_r     <= 32'sd65535;
      bin_count_r <= 9'd256;
      bin_scale_r <= 32'd256;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        CFG_LOWER: lower_r     <= cfg_data;
        CFG_UPPER: upper_r     <= cfg_data;
        CFG_BINS:  bin_count_r <= cfg_data[8:0];
        CFG_SCALE: bin_scale_r <= cfg_data;
        default: begin
          lower_r <= lower_r;
        end
      endcase
    end
  end

  hbu_front #(
    .MAX_BINS(MAX_BINS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_kind       (in_kind),
    .in_sample     (in_sample),
    .in_read_index (in_read_index),
    .cfg_lower     (lower_r),
    .cfg_upper     (upper_r),
    .cfg_bin_count (bin_count_r),
    .cfg_bin_scale (bin_scale_r),
    .q_push        (q_push),
    .q_full        (q_full),
    .q_ctrl        (q_in_ctrl),
    .q_addr        (q_in_addr)
  );

  hbu_cmd_queue #(
    .ADDR_W(BIN_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .full      (q_full),
    .push_ctrl (q_in_ctrl),
    .push_addr (q_in_addr),
    .pop       (q_pop),
    .empty     (q_empty),
    .head_ctrl (q_head_ctrl),
    .head_addr (q_head_addr)
  );

  hbu_back #(
    .MAX_BINS    (MAX_BINS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (q_empty),
    .q_pop             (q_pop),
    .q_ctrl            (q_head_ctrl),
    .q_addr            (q_head_addr),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_bin_value     (out_bin_value),
    .out_hit_index     (out_hit_index),
    .out_was_outlier   (out_was_outlier),
    .out_total_samples (out_total_samples),
    .out_outlier_total (out_outlier_total)
  );

`ifndef ASSERT_OFF
  a_pop_not_empty : assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("command popped from empty queue");

  a_push_holds : assert property (@(posedge clk) disable iff (!rst_n)
    q_push && q_full |=> q_push && $stable(q_in_addr) && $stable(q_in_ctrl))
    else $error("stalled command word changed");

  a_reset_no_result : assert property (@(posedge clk)
    !rst_n |=> out_empty)
    else $error("result word present after reset");

  a_full_stalls_intake : assert property (@(posedge clk) disable iff (!rst_n)
    in_full |-> q_full && q_push)
    else $error("intake stalled without a full queue");
`endif

endmodule
`default_nettype wire

@@ tb/sv/histogram_binner_unit_test.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// histogram_binner_unit_test - self-checking bench for histogram_binner_unit
// Pushes sample, read, clear and no-op words through the queue ports and
// works out every result word from a shadow histogram. Each popped word is
// checked field by field in order. Covers range edges, rounding and bin
// saturation, register corners, random traffic under several idle and
// stall mixes, and a long output hold-off that backs up the input side.
// ---------------------------------------------------------------------------
module histogram_binner_unit_test;
  import hbu_pkg::*;

  localparam int BINS        = HBU_MAX_BINS;
  localparam int QUIET_LIMIT = 4000;
  localparam int SETTLE      = 16;
  localparam int TAIL        = 400;
  localparam int MAX_REPORTS = 40;

  typedef struct {
    logic [31:0] bin_value;
    logic [7:0]  hit_index;
    logic        was_outlier;
    logic [31:0] total_samples;
    logic [31:0] outlier_total;
  } tally_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_push = 1'b0;
  logic                 in_full;
  logic [1:0]           in_kind = KIND_BIN;
  logic signed [31:0]   in_sample = '0;
  logic [7:0]           in_read_index = '0;
  logic                 out_empty;
  logic                 out_pop = 1'b0;
  logic [31:0]          out_bin_value;
  logic [7:0]           out_hit_index;
  logic                 out_was_outlier;
  logic [31:0]          out_total_samples;
  logic [31:0]          out_outlier_total;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data = '0;

  // shadow histogram and register copies
  logic [31:0]        shadow_bins [BINS];
  logic [31:0]        shadow_samples;
  logic [31:0]        shadow_outliers;
  logic signed [31:0] set_lower;
  logic signed [31:0] set_upper;
  logic [8:0]         set_bins;
  logic [31:0]        set_scale;

  tally_t tallies_due [$];
  int     send_idle_pct = 0;
  int     pop_stall_pct = 0;
  int     pop_hold_left = 0;
  int     mismatches = 0;
  int     words_seen = 0;
  int     quiet_cycles = 0;

  histogram_binner_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_kind           (in_kind),
    .in_sample         (in_sample),
    .in_read_index     (in_read_index),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_bin_value     (out_bin_value),
    .out_hit_index     (out_hit_index),
    .out_was_outlier   (out_was_outlier),
    .out_total_samples (out_total_samples),
    .out_outlier_total (out_outlier_total),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always #2 clk = ~clk;

  function automatic logic [31:0] bump(logic [31:0] c);
    return (c == '1) ? c : c + 32'd1;
  endfunction

  function automatic void clear_shadow();
    foreach (shadow_bins[i]) shadow_bins[i] = '0;
    shadow_samples  = '0;
    shadow_outliers = '0;
  endfunction

  // expected result word for one accepted input word; updates the shadow state
  function automatic tally_t tally_item(kind_t k, logic signed [31:0] s, logic [7:0] ridx);
    tally_t      t;
    int unsigned n;
    bit [63:0]   off;
    bit [63:0]   idx;
    t = '{default: '0};
    n = (set_bins == 0) ? 1 : (set_bins > BINS) ? BINS : int'(set_bins);
    case (k)
      KIND_BIN: begin
        shadow_samples = bump(shadow_samples);
        if (s > set_upper || s < set_lower) begin
          shadow_outliers = bump(shadow_outliers);
          t.was_outlier   = 1'b1;
        end else begin
          off = 64'(longint'(s) - longint'(set_lower));
          idx = (off * {32'd0, set_scale} + 64'h8000) >> 16;
          if (idx > 64'(n - 1)) idx = 64'(n - 1);
          shadow_bins[idx[7:0]] = bump(shadow_bins[idx[7:0]]);
          t.bin_value = shadow_bins[idx[7:0]];
          t.hit_index = idx[7:0];
        end
      end
      KIND_READ: begin
        if (int'(ridx) < n) t.bin_value = shadow_bins[ridx];
      end
      KIND_CLEAR: clear_shadow();
      default: ;
    endcase
    t.total_samples = shadow_samples;
    t.outlier_total = shadow_outliers;
    return t;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("mismatch: %s on word %0d, got %h, want %h", what, words_seen, got, want);
  endtask

  // result checker
  always @(posedge clk) begin
    tally_t w;
    if (rst_n && out_pop && !out_empty) begin
      if (tallies_due.size() == 0) begin
        report_mismatch("word with none due", out_bin_value, '0);
      end else begin
        w = tallies_due.pop_front();
        if (out_bin_value !== w.bin_value)
          report_mismatch("bin_value", out_bin_value, w.bin_value);
        if (out_hit_index !== w.hit_index)
          report_mismatch("hit_index", 32'(out_hit_index), 32'(w.hit_index));
        if (out_was_outlier !== w.was_outlier)
          report_mismatch("was_outlier", 32'(out_was_outlier), 32'(w.was_outlier));
        if (out_total_samples !== w.total_samples)
          report_mismatch("total_samples", out_total_samples, w.total_samples);
        if (out_outlier_total !== w.outlier_total)
          report_mismatch("outlier_total", out_outlier_total, w.outlier_total);
      end
      words_seen++;
    end
  end

  // receiver: random stalls, or a counted hold-off when one is requested
  always @(negedge clk) begin
    if (pop_hold_left > 0) begin
      out_pop = 1'b0;
      pop_hold_left--;
    end else begin
      out_pop = ($urandom_range(99) >= pop_stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send_item(kind_t k, logic signed [31:0] s, logic [7:0] ridx);
    @(negedge clk);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_push = 1'b0;
      @(negedge clk);
    end
    in_push       = 1'b1;
    in_kind       = k;
    in_sample     = s;
    in_read_index = ridx;
    do @(posedge clk); while (in_full !== 1'b0);
    tallies_due.push_back(tally_item(k, s, ridx));
  endtask

  task automatic settle_traffic();
    @(negedge clk);
    in_push = 1'b0;
    while (tallies_due.size() != 0) @(posedge clk);
  endtask

  // all four registers, written only once every due word has come back
  task automatic write_settings(logic signed [31:0] lo, logic signed [31:0] hi,
                                logic [31:0] nbins, logic [31:0] scale);
    cfg_reg_t    r;
    logic [31:0] d;
    while (tallies_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(negedge clk);
    for (int i = 0; i < 4; i++) begin
      r = cfg_reg_t'(i);
      case (r)
        CFG_LOWER: d = lo;
        CFG_UPPER: d = hi;
        CFG_BINS:  d = nbins;
        default:   d = scale;
      endcase
      @(negedge clk);
      cfg_valid = 1'b1;
      cfg_index = r;
      cfg_data  = d;
      do @(posedge clk); while (cfg_ready !== 1'b1);
      case (r)
        CFG_LOWER: set_lower = d;
        CFG_UPPER: set_upper = d;
        CFG_BINS:  set_bins  = d[8:0];
        default:   set_scale = d;
      endcase
    end
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic send_random_item();
    int unsigned        pick;
    kind_t              k;
    logic signed [31:0] s;
    longint             span;
    pick = $urandom_range(99);
    if (pick < 70) k = KIND_BIN;
    else if (pick < 90) k = KIND_READ;
    else if (pick < 95) k = KIND_CLEAR;
    else k = KIND_NOP;
    span = longint'(set_upper) - longint'(set_lower);
    pick = $urandom_range(99);
    if (span < 0 || pick < 20) s = $urandom;
    else if (pick < 23) s = set_lower - 1;
    else if (pick < 26) s = set_upper + 1;
    else if (pick < 28) s = set_lower;
    else if (pick < 30) s = set_upper;
    else s = 32'(longint'(set_lower) + longint'($urandom_range(32'(span))));
    send_item(k, s, 8'($urandom_range(255)));
  endtask

  // reset settings: edges of the range, rounding, last-bin saturation
  task automatic test_reset_defaults();
    send_item(KIND_BIN, 0, 8'd0);
    send_item(KIND_BIN, 127, 8'd0);
    send_item(KIND_BIN, 128, 8'd0);
    send_item(KIND_BIN, 65535, 8'd0);
    send_item(KIND_BIN, 65536, 8'd0);
    send_item(KIND_BIN, -1, 8'd0);
    send_item(KIND_BIN, 32'sh7FFFFFFF, 8'hFF);
    send_item(KIND_BIN, 32'sh80000000, 8'h00);
    send_item(KIND_READ, 32'sh5A5A5A5A, 8'd0);
    send_item(KIND_READ, 32'shA5A5A5A5, 8'd1);
    send_item(KIND_READ, 0, 8'd255);
    send_item(KIND_NOP, 32'shFFFFFFFF, 8'hAA);
    send_item(KIND_CLEAR, 0, 8'h55);
    send_item(KIND_READ, 0, 8'd255);
    settle_traffic();
  endtask

  task automatic test_register_corners();
    write_settings(0, 100, 4, 32'h0001_0000);
    send_item(KIND_BIN, 100, 8'd0);
    send_item(KIND_READ, 0, 8'd3);
    send_item(KIND_READ, 0, 8'd10);
    settle_traffic();
    // zero bins acts as a single bin
    write_settings(0, 100, 0, 32'h0001_0000);
    send_item(KIND_BIN, 50, 8'd0);
    settle_traffic();
    // full signed range, widest scale, bin count above the store size
    write_settings(32'sh80000000, 32'sh7FFFFFFF, 300, 32'hFFFF_FFFF);
    send_item(KIND_BIN, 32'sh7FFFFFFF, 8'd0);
    send_item(KIND_BIN, 32'sh80000000, 8'd0);
    settle_traffic();
    // lower above upper: nothing lands in a bin
    write_settings(100, 50, 256, 32'h0000_0100);
    send_item(KIND_BIN, 75, 8'd0);
    settle_traffic();
    write_settings(0, 32'sh7FFFFFFF, 256, 0);
    send_item(KIND_BIN, 12345, 8'd0);
    settle_traffic();
  endtask

  task automatic test_random_mix(int idle_pct, int stall_pct, int count,
                                 int unsigned nbins, bit wide);
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    longint             span;
    logic [31:0]        scale;
    lo    = wide ? $urandom : int'($urandom_range(2000)) - 1000;
    span  = wide ? longint'($urandom) : longint'($urandom_range(5000, 20));
    hi    = (longint'(lo) + span > 64'sd2147483647) ? 32'sh7FFFFFFF : 32'(longint'(lo) + span);
    scale = 32'((64'(nbins) << 16) / (64'(span) + 1)) + $urandom_range(15);
    write_settings(lo, hi, nbins, scale);
    send_idle_pct = idle_pct;
    pop_stall_pct = stall_pct;
    repeat (count) send_random_item();
    settle_traffic();
  endtask

  // receiver holds off while the sender keeps pushing, so the input backs up
  task automatic test_output_holdoff();
    send_idle_pct = 0;
    pop_stall_pct = 0;
    @(posedge clk);
    pop_hold_left = 300;
    repeat (40) send_random_item();
    settle_traffic();
  endtask

  initial begin
    set_lower = 0;
    set_upper = 65535;
    set_bins  = 9'd256;
    set_scale = 32'd256;
    clear_shadow();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_defaults();
    test_register_corners();
    test_random_mix(0, 0, 140, 256, 1'b0);
    test_random_mix(63, 0, 140, $urandom_range(255, 2), 1'b0);
    test_random_mix(0, 63, 140, 1, 1'b0);
    test_random_mix(12, 12, 140, $urandom_range(256, 1), 1'b1);
    test_output_holdoff();

    send_idle_pct = 0;
    pop_stall_pct = 0;
    repeat (TAIL) @(posedge clk);
    if (mismatches == 0 && tallies_due.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
